### rtl/rlfg_pkg.sv
// Package for the rainbow LED frame generator.
// Holds field widths, hue constants, register indexes, FSM type and payload structs.
// No dependencies.
package rlfg_pkg;

  // Field widths
  localparam int PHASE_W     = 15;
  localparam int LED_COUNT_W = 7;
  localparam int BRIGHT_W    = 8;
  localparam int LED_INDEX_W = 6;
  localparam int CHAN_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int FRAC_W      = 12;
  localparam int SECTOR_W    = 3;

  // Default strip length limit
  localparam int MAX_LEDS_DEF = 64;

  // Hue wheel: 1/64 degree units, six sectors per turn
  localparam logic [PHASE_W-1:0] HUE_TURN   = 15'd23040;
  localparam logic [PHASE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [CHAN_W-1:0]  CHAN_FULL  = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSED   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST  = 7'd64;
  localparam logic [BRIGHT_W-1:0]    BRIGHTNESS_RST = 8'd255;

  // Frame sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } seq_state_e;

  // Input word
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
  } frame_req_t;

  // Output word
  typedef struct packed {
    logic [LED_INDEX_W-1:0] led_index;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;
    logic                   last;
  } pixel_t;

  // Index and end-of-frame flag traveling with a pixel
  typedef struct packed {
    logic [LED_INDEX_W-1:0] led_index;
    logic                   last;
  } pix_tag_t;

  // floor(p / 255) for a 16-bit product: (p + (p >> 8) + 1) >> 8
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
    logic [16:0] sum;
    sum = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

### rtl/rlfg_stream_if.sv
// Valid/ready stream channel used for frame requests and pixel words.
// Payload type is a parameter; depends on nothing else.
interface rlfg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/rainbow_led_frame_generator_unit.sv
// Rainbow LED frame generator: top level.
// Uses rlfg_pkg and rlfg_stream_if.
//
// A frame request carries a hue phase; the block answers with one pixel word per
// LED, in position order, the last one flagged. After a request is taken, a
// bit-serial divider forms 23040/n (n is led_count, clamped to at least 1 and at
// most MAX_LEDS), then the hue stepper issues one pixel per cycle while the output
// is not stalled. in_i.ready stays low from the request until the last pixel of
// the frame has been issued, so no new request is taken while a frame is in progress.
// Pixels reach the output through a five-stage pipeline (hue step, sector split,
// channel ramp, brightness multiply, divide by 255 into the output register).
// Backpressure on the output freezes the whole pipeline and the stepper.
// Configuration is sampled per frame (led_count) or used live (brightness,
// reversed) and must only change between frames.
module rainbow_led_frame_generator_unit #(
  parameter int MAX_LEDS = rlfg_pkg::MAX_LEDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rlfg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rlfg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  rlfg_stream_if.sink                         in_i,
  rlfg_stream_if.source                       out_o
);

  // led_count is 7 bits wide, so positions never exceed 126 regardless of MAX_LEDS
  localparam int NMAX  = (MAX_LEDS < 127) ? MAX_LEDS : 127;
  localparam int POS_W = (NMAX > 1) ? $clog2(NMAX) : 1;
  localparam int CNT_W = rlfg_pkg::LED_COUNT_W;
  localparam int PH_W  = rlfg_pkg::PHASE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CNT_W-1:0]              led_count_q;
  logic [rlfg_pkg::BRIGHT_W-1:0] brightness_q;
  logic                          reversed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q  <= rlfg_pkg::LED_COUNT_RST;
      brightness_q <= rlfg_pkg::BRIGHTNESS_RST;
      reversed_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rlfg_pkg::CFG_LED_COUNT:  led_count_q  <= cfg_data_i[CNT_W-1:0];
        rlfg_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i;
        rlfg_pkg::CFG_REVERSED:   reversed_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Frame sequencer
  rlfg_pkg::seq_state_e state_q, state_d;
  logic in_ready;
  logic issue;
  logic div_run;
  logic en;
  logic last_issue;

  logic [3:0]       div_cnt_q, div_cnt_d;
  logic [PH_W-1:0]  div_rq_q, div_rq_d;   // dividend in, quotient out
  logic [CNT_W-1:0] div_rem_q, div_rem_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [PH_W-1:0]  hue_q, hue_d;
  logic [CNT_W-1:0] acc_q, acc_d;
  logic [POS_W-1:0] pos_q, pos_d;

  wire accept = in_i.valid & in_ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rlfg_pkg::ST_IDLE: if (accept) state_d = rlfg_pkg::ST_DIV;
      rlfg_pkg::ST_DIV:  if (div_cnt_q == 4'd0) state_d = rlfg_pkg::ST_RUN;
      rlfg_pkg::ST_RUN:  if (en && last_issue) state_d = rlfg_pkg::ST_IDLE;
      default:           state_d = rlfg_pkg::ST_IDLE;
    endcase
  end

  // State decoded controls
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    div_run  = 1'b0;
    case (state_q)
      rlfg_pkg::ST_IDLE: in_ready = 1'b1;
      rlfg_pkg::ST_DIV:  div_run  = 1'b1;
      rlfg_pkg::ST_RUN:  issue    = 1'b1;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rlfg_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Saturated LED count for the new frame
  always_comb begin
    if (led_count_q == '0)                n_d = CNT_W'(1);
    else if (int'(led_count_q) > MAX_LEDS) n_d = CNT_W'(MAX_LEDS);
    else                                   n_d = led_count_q;
  end

  // Restoring divider: 23040 / n, one quotient bit per cycle
  logic [CNT_W:0] div_trial;
  logic           div_ge;
  always_comb begin
    div_trial = {div_rem_q, div_rq_q[PH_W-1]};
    div_ge    = div_trial >= {1'b0, n_q};
  end

  // Hue stepper: hue += quotient, plus one when the remainder accumulator wraps
  logic [CNT_W:0]  acc_sum;
  logic            acc_carry;
  logic [PH_W:0]   hue_sum;
  logic [PH_W-1:0] phase_red;

  always_comb begin
    acc_sum   = {1'b0, acc_q} + {1'b0, div_rem_q};
    acc_carry = acc_sum >= {1'b0, n_q};
    hue_sum   = {1'b0, hue_q} + {1'b0, div_rq_q} + {{PH_W{1'b0}}, acc_carry};
    phase_red = (in_i.data.phase >= rlfg_pkg::HUE_TURN) ?
                in_i.data.phase - rlfg_pkg::HUE_TURN : in_i.data.phase;
    last_issue = ({{(CNT_W-POS_W){1'b0}}, pos_q} == n_q - CNT_W'(1));
  end

  always_comb begin
    div_cnt_d = div_cnt_q;
    div_rq_d  = div_rq_q;
    div_rem_d = div_rem_q;
    hue_d     = hue_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    if (accept) begin
      div_cnt_d = 4'(PH_W - 1);
      div_rq_d  = rlfg_pkg::HUE_TURN;
      div_rem_d = '0;
      hue_d     = phase_red;
      acc_d     = '0;
      pos_d     = '0;
    end else if (div_run) begin
      div_cnt_d = div_cnt_q - 4'd1;
      div_rq_d  = {div_rq_q[PH_W-2:0], div_ge};
      div_rem_d = div_ge ? CNT_W'(div_trial - {1'b0, n_q}) : div_trial[CNT_W-1:0];
    end else if (issue && en) begin
      acc_d = acc_carry ? CNT_W'(acc_sum - {1'b0, n_q}) : acc_sum[CNT_W-1:0];
      hue_d = (hue_sum >= {1'b0, rlfg_pkg::HUE_TURN}) ?
              PH_W'(hue_sum - {1'b0, rlfg_pkg::HUE_TURN}) : hue_sum[PH_W-1:0];
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    div_cnt_q <= div_cnt_d;
    div_rq_q  <= div_rq_d;
    div_rem_q <= div_rem_d;
    hue_q     <= hue_d;
    acc_q     <= acc_d;
    pos_q     <= pos_d;
    if (accept) n_q <= n_d;
  end

  // Strip index, mirrored when reversed
  logic [CNT_W-1:0]      idx_full;
  rlfg_pkg::pix_tag_t    tag0;
  always_comb begin
    idx_full = reversed_q ? n_q - CNT_W'(1) - CNT_W'(pos_q) : CNT_W'(pos_q);
    tag0.led_index = idx_full[rlfg_pkg::LED_INDEX_W-1:0];
    tag0.last      = last_issue;
  end

  // ---------------------------------------------------------------------------
  // Pixel pipeline; one shared enable, frozen while the output word waits
  logic v1_q, v2_q, v3_q, v4_q;
  assign en = !v4_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: split hue into sector and position within it
  logic [rlfg_pkg::SECTOR_W-1:0] sector_d, sector_q;
  logic [PH_W-1:0]               base;
  logic [rlfg_pkg::FRAC_W-1:0]   frac_d, frac_q;
  rlfg_pkg::pix_tag_t            tag1_q, tag2_q, tag3_q;

  always_comb begin
    if (hue_q >= 5 * rlfg_pkg::HUE_SECTOR)      sector_d = 3'd5;
    else if (hue_q >= 4 * rlfg_pkg::HUE_SECTOR) sector_d = 3'd4;
    else if (hue_q >= 3 * rlfg_pkg::HUE_SECTOR) sector_d = 3'd3;
    else if (hue_q >= 2 * rlfg_pkg::HUE_SECTOR) sector_d = 3'd2;
    else if (hue_q >= rlfg_pkg::HUE_SECTOR)     sector_d = 3'd1;
    else                                        sector_d = 3'd0;
    base   = PH_W'(sector_d * rlfg_pkg::HUE_SECTOR);
    frac_d = rlfg_pkg::FRAC_W'(hue_q - base);
  end

  // Stage 2: ramps are frac*255/3840 = frac*17/256
  logic [15:0] up_p, down_p;
  logic [rlfg_pkg::CHAN_W-1:0] up, down;
  logic [rlfg_pkg::CHAN_W-1:0] r_d, g_d, b_d, r_q, g_q, b_q;

  always_comb begin
    up_p   = 16'(frac_q) * 16'd17;
    down_p = 16'(rlfg_pkg::FRAC_W'(rlfg_pkg::HUE_SECTOR) - frac_q) * 16'd17;
    up     = up_p[15:8];
    down   = down_p[15:8];
    r_d = '0;
    g_d = '0;
    b_d = '0;
    case (sector_q)
      3'd0: begin r_d = rlfg_pkg::CHAN_FULL; g_d = up; end
      3'd1: begin r_d = down; g_d = rlfg_pkg::CHAN_FULL; end
      3'd2: begin g_d = rlfg_pkg::CHAN_FULL; b_d = up; end
      3'd3: begin g_d = down; b_d = rlfg_pkg::CHAN_FULL; end
      3'd4: begin r_d = up; b_d = rlfg_pkg::CHAN_FULL; end
      default: begin r_d = rlfg_pkg::CHAN_FULL; b_d = down; end
    endcase
  end

  // Stage 3: brightness products
  logic [15:0] pr_q, pg_q, pb_q;

  // Stage 4: divide by 255 into the output word
  rlfg_pkg::pixel_t pix_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sector_q <= sector_d;
      frac_q   <= frac_d;
      tag1_q   <= tag0;

      r_q    <= r_d;
      g_q    <= g_d;
      b_q    <= b_d;
      tag2_q <= tag1_q;

      pr_q   <= 16'(r_q) * 16'(brightness_q);
      pg_q   <= 16'(g_q) * 16'(brightness_q);
      pb_q   <= 16'(b_q) * 16'(brightness_q);
      tag3_q <= tag2_q;

      pix_q.led_index <= tag3_q.led_index;
      pix_q.red       <= rlfg_pkg::div255(pr_q);
      pix_q.green     <= rlfg_pkg::div255(pg_q);
      pix_q.blue      <= rlfg_pkg::div255(pb_q);
      pix_q.last      <= tag3_q.last;
    end
  end

  assign out_o.valid = v4_q;
  assign out_o.data  = pix_q;

endmodule
